>>> rtl/core/rcld_pkg.sv
// Shared types and constants for the row change list deframer.
`timescale 1ns / 1ps
`default_nettype none

package rcld_pkg;

    // Result queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] CFG_UPDATE_CODE   = 2'd0;
    localparam logic [1:0] CFG_DELETE_CODE   = 2'd1;
    localparam logic [1:0] CFG_REINSERT_CODE = 2'd2;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TYPE  = 3'd0,
        PH_ID    = 3'd1,
        PH_SIZE  = 3'd2,
        PH_VALUE = 3'd3,
        PH_DROP  = 3'd4
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_TYPE_HDR = 2'd0,
        KIND_COL_HDR  = 2'd1,
        KIND_VALUE    = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    // List type
    typedef enum logic [1:0] {
        LT_UPDATE   = 2'd0,
        LT_DELETE   = 2'd1,
        LT_REINSERT = 2'd2
    } t_list_type;

    // Error codes
    typedef enum logic [2:0] {
        ERR_BAD_TYPE     = 3'd0,
        ERR_DELETE_LONG  = 3'd1,
        ERR_EMPTY_UPDATE = 3'd2,
        ERR_BAD_ID       = 3'd3,
        ERR_BAD_SIZE     = 3'd4,
        ERR_TRUNCATED    = 3'd5
    } t_err;

    // Type byte codes from the configuration registers
    typedef struct packed {
        logic [7:0] update_code;
        logic [7:0] delete_code;
        logic [7:0] reinsert_code;
    } t_codes;

    // One result item as it travels through the queue
    typedef struct packed {
        t_kind       kind;
        t_list_type  list_type;
        logic [31:0] col_id;
        logic        is_null;
        logic [31:0] value_len;
        logic [7:0]  value_byte;
        logic        value_end;
        t_err        error_code;
        logic        list_done;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/rcld_in_if.sv
// Input byte channel: valid/ready with one raw byte and a last flag.
`timescale 1ns / 1ps
`default_nettype none

interface rcld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       list_last;

    modport source (output valid, output data_byte, output list_last, input ready);
    modport sink   (input valid, input data_byte, input list_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rcld_out_if.sv
// Result channel: valid/ready with the decoded result fields.
`timescale 1ns / 1ps
`default_nettype none

interface rcld_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  list_type;
    logic [31:0] col_id;
    logic        is_null;
    logic [31:0] value_len;
    logic [7:0]  value_byte;
    logic        value_end;
    logic [2:0]  error_code;
    logic        list_done;

    modport source (
        output valid, output kind, output list_type, output col_id,
        output is_null, output value_len, output value_byte, output value_end,
        output error_code, output list_done, input ready
    );
    modport sink (
        input valid, input kind, input list_type, input col_id,
        input is_null, input value_len, input value_byte, input value_end,
        input error_code, input list_done, output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/rcld_front.sv
// Front end: byte parser that classifies each input item and pushes its result.
`timescale 1ns / 1ps
`default_nettype none

module rcld_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rcld_pkg::t_codes i_codes,
    rcld_in_if.sink               i_in,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output rcld_pkg::t_result     o_push_data
);
    import rcld_pkg::*;

    t_phase      r_phase, n_phase;
    t_list_type  r_kol, n_kol;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_nb, n_nb;
    logic [31:0] r_held, n_held;
    logic [31:0] r_left, n_left;

    logic        fire;
    logic [7:0]  b;
    logic        last;
    logic [38:0] sh;
    logic [31:0] v_acc;
    logic        v_broken;
    logic        v_pending;
    logic        v_complete;
    logic [31:0] size_m1;
    logic        do_fail;
    t_err        f_code;
    logic [31:0] f_cid;
    t_result     res;
    logic        res_v;

    assign i_in.ready = !i_q_full;
    assign fire       = i_in.valid && !i_q_full;
    assign b          = i_in.data_byte;
    assign last       = i_in.list_last;

    // Varint byte step: place 7 payload bits at the current group
    always_comb begin
        unique case (r_nb)
            3'd0:    sh = {32'b0, b[6:0]};
            3'd1:    sh = {25'b0, b[6:0], 7'b0};
            3'd2:    sh = {18'b0, b[6:0], 14'b0};
            3'd3:    sh = {11'b0, b[6:0], 21'b0};
            3'd4:    sh = {4'b0, b[6:0], 28'b0};
            default: sh = '0;
        endcase
        v_acc      = r_acc | sh[31:0];
        v_broken   = (r_nb > 3'd4) || (b[7] && (r_nb >= 3'd4));
        v_pending  = b[7] && !v_broken;
        v_complete = !b[7] && !(r_nb > 3'd4);
        size_m1    = v_acc - 32'd1;
    end

    // Parser next state and result
    always_comb begin
        n_phase = r_phase;
        n_kol   = r_kol;
        n_acc   = r_acc;
        n_nb    = r_nb;
        n_held  = r_held;
        n_left  = r_left;
        res     = '0;
        res_v   = 1'b0;
        do_fail = 1'b0;
        f_code  = ERR_BAD_TYPE;
        f_cid   = '0;

        if (fire) begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_held = '0;
                    n_left = '0;
                    priority if (b == i_codes.update_code) begin
                        n_kol = LT_UPDATE;
                        if (last) begin
                            do_fail = 1'b1;
                            f_code  = ERR_EMPTY_UPDATE;
                        end
                    end else if (b == i_codes.delete_code) begin
                        n_kol = LT_DELETE;
                        if (!last) begin
                            do_fail = 1'b1;
                            f_code  = ERR_DELETE_LONG;
                        end
                    end else if (b == i_codes.reinsert_code) begin
                        n_kol = LT_REINSERT;
                    end else begin
                        n_kol   = LT_UPDATE;
                        do_fail = 1'b1;
                        f_code  = ERR_BAD_TYPE;
                    end
                    if (!do_fail) begin
                        res_v         = 1'b1;
                        res.kind      = KIND_TYPE_HDR;
                        res.list_type = n_kol;
                        res.list_done = last;
                        if (last) begin
                            n_phase = PH_TYPE;
                        end else begin
                            n_phase = PH_ID;
                            n_acc   = '0;
                            n_nb    = '0;
                        end
                    end
                end
                PH_ID: begin
                    n_acc = v_acc;
                    if (v_broken) begin
                        do_fail = 1'b1;
                        f_code  = ERR_BAD_ID;
                    end else if (v_pending) begin
                        n_nb = r_nb + 3'd1;
                        if (last) begin
                            do_fail = 1'b1;
                            f_code  = ERR_BAD_ID;
                        end
                    end else begin
                        n_held = v_acc;
                        if (last) begin
                            do_fail = 1'b1;
                            f_code  = ERR_BAD_SIZE;
                            f_cid   = v_acc;
                        end else begin
                            n_phase = PH_SIZE;
                            n_acc   = '0;
                            n_nb    = '0;
                        end
                    end
                end
                PH_SIZE: begin
                    n_acc = v_acc;
                    if (v_broken || (v_pending && last)) begin
                        do_fail = 1'b1;
                        f_code  = ERR_BAD_SIZE;
                        f_cid   = r_held;
                    end else if (v_pending) begin
                        n_nb = r_nb + 3'd1;
                    end else if (v_complete) begin
                        if (v_acc == 32'd0) begin
                            // null column
                            res_v         = 1'b1;
                            res.kind      = KIND_COL_HDR;
                            res.list_type = r_kol;
                            res.col_id    = r_held;
                            res.is_null   = 1'b1;
                            res.list_done = last;
                            if (last) begin
                                n_phase = PH_TYPE;
                            end else begin
                                n_phase = PH_ID;
                                n_acc   = '0;
                                n_nb    = '0;
                            end
                        end else begin
                            n_left = size_m1;
                            if ((size_m1 != 32'd0) && last) begin
                                do_fail = 1'b1;
                                f_code  = ERR_TRUNCATED;
                                f_cid   = r_held;
                            end else begin
                                res_v         = 1'b1;
                                res.kind      = KIND_COL_HDR;
                                res.list_type = r_kol;
                                res.col_id    = r_held;
                                res.value_len = size_m1;
                                res.list_done = last;
                                if (size_m1 != 32'd0) begin
                                    n_phase = PH_VALUE;
                                end else if (last) begin
                                    n_phase = PH_TYPE;
                                end else begin
                                    n_phase = PH_ID;
                                    n_acc   = '0;
                                    n_nb    = '0;
                                end
                            end
                        end
                    end
                end
                PH_VALUE: begin
                    if (r_left == 32'd0) begin
                        if (last) begin
                            n_phase = PH_TYPE;
                        end else begin
                            n_phase = PH_ID;
                            n_acc   = '0;
                            n_nb    = '0;
                        end
                    end else if (last && (r_left > 32'd1)) begin
                        do_fail = 1'b1;
                        f_code  = ERR_TRUNCATED;
                        f_cid   = r_held;
                    end else begin
                        n_left         = r_left - 32'd1;
                        res_v          = 1'b1;
                        res.kind       = KIND_VALUE;
                        res.list_type  = r_kol;
                        res.col_id     = r_held;
                        res.value_byte = b;
                        res.value_end  = (r_left == 32'd1);
                        res.list_done  = last;
                        if (r_left == 32'd1) begin
                            if (last) begin
                                n_phase = PH_TYPE;
                            end else begin
                                n_phase = PH_ID;
                                n_acc   = '0;
                                n_nb    = '0;
                            end
                        end
                    end
                end
                PH_DROP: begin
                    n_phase = last ? PH_TYPE : PH_DROP;
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase

            // Error result: skip the rest of the list unless it ends here
            if (do_fail) begin
                res_v          = 1'b1;
                res            = '0;
                res.kind       = KIND_ERROR;
                res.list_type  = (f_code == ERR_BAD_TYPE) ? LT_UPDATE : n_kol;
                res.col_id     = f_cid;
                res.error_code = f_code;
                res.list_done  = last;
                n_phase        = last ? PH_TYPE : PH_DROP;
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_kol   <= LT_UPDATE;
            r_acc   <= '0;
            r_nb    <= '0;
            r_held  <= '0;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_kol   <= n_kol;
            r_acc   <= n_acc;
            r_nb    <= n_nb;
            r_held  <= n_held;
            r_left  <= n_left;
        end
    end

    assign o_push      = res_v;
    assign o_push_data = res;

endmodule

`default_nettype wire

>>> rtl/core/rcld_queue.sv
// Small result queue between the parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module rcld_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rcld_pkg::t_result i_push_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output rcld_pkg::t_result      o_pop_data,
    output logic                   o_empty
);
    import rcld_pkg::*;

    t_result                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count, n_count;
    logic                   push_ok;
    logic                   pop_ok;

    assign o_full     = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rcld_back.sv
// Back end: output register that drains the queue onto the result channel.
`timescale 1ns / 1ps
`default_nettype none

module rcld_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire rcld_pkg::t_result i_q_data,
    output logic                   o_q_pop,
    rcld_out_if.source             o_out
);
    import rcld_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;

    // Load a new item when the register is empty or being taken
    assign o_q_pop = !i_q_empty && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_q_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end
    end

    // Result fields
    assign o_out.valid      = r_valid;
    assign o_out.kind       = r_data.kind;
    assign o_out.list_type  = r_data.list_type;
    assign o_out.col_id     = r_data.col_id;
    assign o_out.is_null    = r_data.is_null;
    assign o_out.value_len  = r_data.value_len;
    assign o_out.value_byte = r_data.value_byte;
    assign o_out.value_end  = r_data.value_end;
    assign o_out.error_code = r_data.error_code;
    assign o_out.list_done  = r_data.list_done;

endmodule

`default_nettype wire

>>> rtl/core/row_change_list_deframer.sv
// Top level of the row change list deframer.
`timescale 1ns / 1ps
`default_nettype none

// Takes an encoded row change list one byte per cycle and emits a type
// header, a column header per entry and one item per value byte, or an
// error item after which the rest of the list is dropped. The parser takes
// one byte every cycle whenever the four-entry result queue has room; a
// byte's result goes through the queue and then the output register.
// Every byte waits while the queue is full, also one that yields no result
// (varint bytes, dropped bytes); only a stalled result port fills the queue.
// Type codes are to be written through the configuration port only while no
// list is in flight; the block itself does not enforce this. Index 0 is the
// update code, 1 delete, 2 reinsert. Value bytes delivered before a
// truncated-value error belong to the broken entry and are to be discarded.
module row_change_list_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rcld_in_if.sink         i_in,
    rcld_out_if.source      o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);
    import rcld_pkg::*;

    t_codes  r_codes;
    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    t_result q_push_data;
    t_result q_pop_data;

    // Type code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.update_code   <= 8'd1;
            r_codes.delete_code   <= 8'd2;
            r_codes.reinsert_code <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPDATE_CODE:   r_codes.update_code   <= i_cfg_data;
                CFG_DELETE_CODE:   r_codes.delete_code   <= i_cfg_data;
                CFG_REINSERT_CODE: r_codes.reinsert_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rcld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_codes     (r_codes),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    rcld_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    rcld_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_pop_data),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the row change list deframer.
`timescale 1ns / 1ps

module tb;
    import rcld_pkg::*;

    localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 150;   // long result-port hold-off
    localparam int SETTLE      = 8;     // idle cycles after the last expected result

    // One row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic [7:0] data;
        bit         last;
        bit         typed;
        bit         has;
        t_result    res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    rcld_in_if  in_if ();
    rcld_out_if out_if ();

    row_change_list_deframer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Deframer model state and type codes
    t_phase      ps_phase;
    t_list_type  ps_list;
    logic [31:0] ps_accum;
    int          ps_nbytes;
    logic [31:0] ps_id;
    logic [31:0] ps_left;
    logic [7:0]  code_upd, code_del, code_rei;

    t_result     pending_results[$];
    logic [7:0]  list_bytes[$];
    t_row        dir_tab[24];

    // Side info that travels with the driven item
    bit          drv_typed, drv_has;
    t_result     drv_res;

    int          mismatches = 0;
    int          items_sent = 0;
    int          items_in = 0;
    int          results_seen = 0;
    int          kind_cnt[4] = '{0, 0, 0, 0};
    logic [5:0]  err_seen = '0;
    int          quiet_cycles = 0;
    int          hold_asks = 0;
    int          hold_given = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    // ---------------------------------------------------------------
    // Deframer model
    // ---------------------------------------------------------------

    function automatic t_result emit(t_kind k, logic [31:0] cid, bit isnull,
                                     logic [31:0] vlen, logic [7:0] vb, bit vend,
                                     bit last);
        t_result r;
        r = '0;
        r.kind       = k;
        r.list_type  = ps_list;
        r.col_id     = cid;
        r.is_null    = isnull;
        r.value_len  = vlen;
        r.value_byte = vb;
        r.value_end  = vend;
        r.list_done  = last;
        return r;
    endfunction

    // Error item; the rest of the list is dropped unless this byte ended it
    function automatic bit raise(t_err code, logic [31:0] cid, bit last,
                                 output t_result r);
        r = emit(KIND_ERROR, cid, 1'b0, '0, '0, 1'b0, last);
        r.error_code = code;
        if (last) ps_phase = PH_TYPE;
        else ps_phase = PH_DROP;
        return 1'b1;
    endfunction

    function automatic void close_entry(bit last);
        if (last) begin
            ps_phase = PH_TYPE;
        end else begin
            ps_accum  = '0;
            ps_nbytes = 0;
            ps_phase  = PH_ID;
        end
    endfunction

    // 0 pending, 1 complete, 2 broken
    function automatic int varint_take(logic [7:0] b);
        logic [63:0] shifted;
        int n;
        n = ps_nbytes;
        if (n > 4) return 2;
        shifted  = {57'd0, b[6:0]} << (7 * n);
        ps_accum = ps_accum | shifted[31:0];
        if (b[7]) begin
            if (n >= 4) return 2;
            ps_nbytes = n + 1;
            return 0;
        end
        return 1;
    endfunction

    // Advance the model by one byte; returns 1 when a result is due
    function automatic bit parse_byte(logic [7:0] b, bit last, output t_result r);
        int vs;
        r = '0;
        case (ps_phase)
            PH_TYPE: begin
                ps_id   = '0;
                ps_left = '0;
                if (b == code_upd) ps_list = LT_UPDATE;
                else if (b == code_del) ps_list = LT_DELETE;
                else if (b == code_rei) ps_list = LT_REINSERT;
                else begin
                    ps_list = LT_UPDATE;
                    return raise(ERR_BAD_TYPE, '0, last, r);
                end
                if (ps_list == LT_DELETE && !last)
                    return raise(ERR_DELETE_LONG, '0, last, r);
                if (ps_list == LT_UPDATE && last)
                    return raise(ERR_EMPTY_UPDATE, '0, last, r);
                r = emit(KIND_TYPE_HDR, '0, 1'b0, '0, '0, 1'b0, last);
                close_entry(last);
                return 1'b1;
            end
            PH_ID: begin
                vs = varint_take(b);
                if (vs == 2) return raise(ERR_BAD_ID, '0, last, r);
                if (vs == 0) begin
                    if (last) return raise(ERR_BAD_ID, '0, last, r);
                    return 1'b0;
                end
                ps_id = ps_accum;
                if (last) return raise(ERR_BAD_SIZE, ps_id, last, r);
                ps_accum  = '0;
                ps_nbytes = 0;
                ps_phase  = PH_SIZE;
                return 1'b0;
            end
            PH_SIZE: begin
                vs = varint_take(b);
                if (vs == 2 || (vs == 0 && last)) return raise(ERR_BAD_SIZE, ps_id, last, r);
                if (vs == 0) return 1'b0;
                if (ps_accum == 0) begin
                    r = emit(KIND_COL_HDR, ps_id, 1'b1, '0, '0, 1'b0, last);
                    close_entry(last);
                    return 1'b1;
                end
                ps_left = ps_accum - 1;
                if (ps_left != 0 && last) return raise(ERR_TRUNCATED, ps_id, last, r);
                r = emit(KIND_COL_HDR, ps_id, 1'b0, ps_left, '0, 1'b0, last);
                if (ps_left == 0) close_entry(last);
                else ps_phase = PH_VALUE;
                return 1'b1;
            end
            PH_VALUE: begin
                if (ps_left == 0) begin
                    close_entry(last);
                    return 1'b0;
                end
                if (last && ps_left > 1) return raise(ERR_TRUNCATED, ps_id, last, r);
                ps_left = ps_left - 1;
                r = emit(KIND_VALUE, ps_id, 1'b0, '0, b, ps_left == 0, last);
                if (ps_left == 0) close_entry(last);
                return 1'b1;
            end
            default: begin
                if (last) ps_phase = PH_TYPE;
                else ps_phase = PH_DROP;
                return 1'b0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Output check first, then model update for the accepted input byte
    always @(posedge i_clk) begin
        t_result want, pred;
        bit has, active;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            active = i_cfg_we;
            if (out_if.valid && out_if.ready) begin
                active = 1'b1;
                results_seen++;
                kind_cnt[out_if.kind]++;
                if (out_if.kind == KIND_ERROR && out_if.error_code <= ERR_TRUNCATED)
                    err_seen[out_if.error_code] = 1'b1;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual kind %0d",
                             $time, out_if.kind);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind",       want.kind,       out_if.kind);
                    check_field("list_type",  want.list_type,  out_if.list_type);
                    check_field("col_id",     want.col_id,     out_if.col_id);
                    check_field("is_null",    want.is_null,    out_if.is_null);
                    check_field("value_len",  want.value_len,  out_if.value_len);
                    check_field("value_byte", want.value_byte, out_if.value_byte);
                    check_field("value_end",  want.value_end,  out_if.value_end);
                    check_field("error_code", want.error_code, out_if.error_code);
                    check_field("list_done",  want.list_done,  out_if.list_done);
                end
            end
            if (in_if.valid && in_if.ready) begin
                active = 1'b1;
                items_in++;
                has = parse_byte(in_if.data_byte, in_if.list_last, pred);
                if (drv_typed) begin
                    has  = drv_has;
                    pred = drv_res;
                end
                if (has) pending_results.insert(pending_results.size(), pred);
            end
            quiet_cycles <= active ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("row_change_list_deframer test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Idle cycles for one item; runs of zero gaps come and go
    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic t_row row(logic [7:0] d, bit l);
        t_row t;
        t.data  = d;
        t.last  = l;
        t.typed = 1'b0;
        t.has   = 1'b0;
        t.res   = '0;
        return t;
    endfunction

    function automatic t_row trow(logic [7:0] d, bit l, bit has, t_result res);
        t_row t;
        t = row(d, l);
        t.typed = 1'b1;
        t.has   = has;
        t.res   = res;
        return t;
    endfunction

    function automatic t_result header_item(t_list_type lt, bit done);
        t_result r;
        r = '0;
        r.kind      = KIND_TYPE_HDR;
        r.list_type = lt;
        r.list_done = done;
        return r;
    endfunction

    function automatic t_result error_item(t_err code, t_list_type lt,
                                           logic [31:0] cid, bit done);
        t_result r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.list_type  = lt;
        r.col_id     = cid;
        r.error_code = code;
        r.list_done  = done;
        return r;
    endfunction

    // Random value with a random number of significant bits
    function automatic logic [31:0] rand_wide();
        int w;
        logic [63:0] m;
        w = $urandom_range(0, 32);
        m = (64'd1 << w) - 1;
        return $urandom & m[31:0];
    endfunction

    // Varint encoding, sometimes padded to up to five bytes; spare top bits random
    task automatic push_varint(logic [31:0] v);
        logic [63:0] w;
        logic [6:0]  b;
        logic        cont;
        int nmin, len;
        w = {32'd0, v};
        nmin = 1;
        while (nmin < 5 && (w >> (7 * nmin)) != 0) nmin++;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(nmin, 5) : nmin;
        for (int i = 0; i < len; i++) begin
            b = w[7 * i +: 7];
            if (i == 4) b[6:4] = $urandom_range(0, 7);
            cont = (i < len - 1);
            list_bytes.insert(list_bytes.size(), {cont, b});
        end
    endtask

    // One column entry; an occasional random-length value ends the list, often cut short (truncated)
    task automatic push_entry(output bit stop);
        logic [31:0] len;
        int r, n;
        stop = 1'b0;
        push_varint(rand_wide());
        r = $urandom_range(0, 19);
        if (r < 4) begin
            push_varint(32'd0);
        end else if (r == 19) begin
            len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFE : rand_wide();
            if (len == 32'hFFFF_FFFF) len = 32'hFFFF_FFFE;
            push_varint(len + 1);
            n = (len < 6) ? len : $urandom_range(0, 6);
            repeat (n) list_bytes.insert(list_bytes.size(), $urandom_range(0, 255));
            stop = 1'b1;
        end else begin
            len = (r == 18) ? $urandom_range(0, 20) : $urandom_range(0, 6);
            push_varint(len + 1);
            repeat (len) list_bytes.insert(list_bytes.size(), $urandom_range(0, 255));
        end
    endtask

    // Build one change list: mostly well formed, the rest cut, broken or noise
    task automatic build_list();
        int mode, t, n, keep;
        bit stop;
        list_bytes.delete();
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            repeat ($urandom_range(1, 6))
                list_bytes.insert(list_bytes.size(), $urandom_range(0, 255));
            return;
        end
        t = (mode == 7) ? 2 * $urandom_range(0, 1) : $urandom_range(0, 2);
        case (t)
            0:       list_bytes.insert(list_bytes.size(), code_upd);
            1:       list_bytes.insert(list_bytes.size(), code_del);
            default: list_bytes.insert(list_bytes.size(), code_rei);
        endcase
        // continuation run in the id or size varint
        if (mode == 8 && $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 1) == 1) push_entry(stop);
            if ($urandom_range(0, 1) == 1) push_varint(rand_wide());
            repeat ($urandom_range(5, 6))
                list_bytes.insert(list_bytes.size(), 8'h80 | $urandom_range(0, 127));
            repeat ($urandom_range(0, 3))
                list_bytes.insert(list_bytes.size(), $urandom_range(0, 255));
            return;
        end
        n = (t == 0) ? $urandom_range(1, 4) : (t == 1) ? 0 : $urandom_range(0, 3);
        stop = 1'b0;
        for (int i = 0; i < n && !stop; i++) push_entry(stop);
        if (mode == 7 && list_bytes.size() > 1) begin
            keep = $urandom_range(1, list_bytes.size() - 1);
            while (list_bytes.size() > keep) void'(list_bytes.pop_back());
        end
        if (mode == 8)
            repeat ($urandom_range(1, 3))
                list_bytes.insert(list_bytes.size(), $urandom_range(0, 255));
    endtask

    task automatic send_byte(logic [7:0] d, bit l, bit typed, bit has, t_result res);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= d;
        in_if.list_last <= l;
        drv_typed       <= typed;
        drv_has         <= has;
        drv_res         <= res;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    // Wait until every expected result is in and the pipeline is empty
    task automatic drain();
        in_if.valid <= 1'b0;
        // let the checker book the last accepted byte first
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_codes(logic [7:0] upd, logic [7:0] del, logic [7:0] rei);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_UPDATE_CODE;
        i_cfg_data <= upd;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DELETE_CODE;
        i_cfg_data <= del;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REINSERT_CODE;
        i_cfg_data <= rei;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        code_upd = upd;
        code_del = del;
        code_rei = rei;
    endtask

    task automatic run_random(int target, bit with_hold);
        int start;
        bit held;
        start = items_sent;
        held  = 1'b0;
        while (items_sent - start < target) begin
            if (with_hold && !held && items_sent - start >= 40) begin
                hold_asks++;
                held = 1'b1;
            end
            build_list();
            foreach (list_bytes[i])
                send_byte(list_bytes[i], i == list_bytes.size() - 1, 1'b0, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // Result port: random stalls plus one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int gap;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_given != hold_asks) begin
                hold_given++;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_UPDATE_CODE;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.list_last = 1'b0;
        drv_typed       = 1'b0;
        drv_has         = 1'b0;
        drv_res         = '0;

        // model reset state
        code_upd  = 8'd1;
        code_del  = 8'd2;
        code_rei  = 8'd3;
        ps_phase  = PH_TYPE;
        ps_list   = LT_UPDATE;
        ps_accum  = '0;
        ps_nbytes = 0;
        ps_id     = '0;
        ps_left   = '0;

        // Directed lists under reset codes
        dir_tab = '{
            trow(8'hFF, 1'b1, 1'b1, error_item(ERR_BAD_TYPE, LT_UPDATE, 32'd0, 1'b1)),
            trow(8'h02, 1'b1, 1'b1, header_item(LT_DELETE, 1'b1)),
            trow(8'h01, 1'b1, 1'b1, error_item(ERR_EMPTY_UPDATE, LT_UPDATE, 32'd0, 1'b1)),
            trow(8'h03, 1'b1, 1'b1, header_item(LT_REINSERT, 1'b1)),
            trow(8'h02, 1'b0, 1'b1, error_item(ERR_DELETE_LONG, LT_DELETE, 32'd0, 1'b0)),
            trow(8'hAA, 1'b1, 1'b0, '0),           // dropped tail
            row(8'h01, 1'b0),                      // update list
            row(8'hFF, 1'b0), row(8'hFF, 1'b0), row(8'hFF, 1'b0), row(8'hFF, 1'b0),
            row(8'h7F, 1'b0),                      // five-byte id, top bits dropped
            row(8'h00, 1'b0),                      // null value
            row(8'h00, 1'b0), row(8'h03, 1'b0),    // id 0, two bytes
            row(8'h00, 1'b0), row(8'hFF, 1'b0),
            trow(8'h85, 1'b1, 1'b1, error_item(ERR_BAD_ID, LT_UPDATE, 32'd0, 1'b1)),
            row(8'h03, 1'b0),                      // reinsert, list ends after id
            trow(8'h07, 1'b1, 1'b1, error_item(ERR_BAD_SIZE, LT_REINSERT, 32'd7, 1'b1)),
            row(8'h01, 1'b0), row(8'h09, 1'b0), row(8'h04, 1'b0),
            row(8'hAB, 1'b1)                       // value cut short
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed,
                      dir_tab[i].has, dir_tab[i].res);
        drain();

        // Random lists across several code settings
        run_random(150, 1'b0);
        drain();
        write_codes(8'h00, 8'hFF, 8'h80);
        run_random(140, 1'b1);
        drain();
        write_codes(8'h7E, 8'h7E, 8'h7E);      // all equal: update wins
        run_random(100, 1'b0);
        drain();
        write_codes(8'h10, 8'h41, 8'h41);      // delete wins over reinsert
        run_random(100, 1'b0);
        drain();
        write_codes($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(200, 1'b0);
        drain();

        $display("Covered %0d bytes over 5 type-code settings; %0d results checked.",
                 items_in, results_seen);
        $display("Headers %0d, columns %0d, values %0d, errors %0d (codes seen %b).",
                 kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], err_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("row_change_list_deframer test passed");
        else
            $display("row_change_list_deframer test failed");
        $finish;
    end

endmodule
